FILE: hw/rtl/ppr_pkg.sv
// Package for the pulse period to rate meter.
// Holds the phase and sequencer types, register indexes and divider constants.
// No dependencies.
package ppr_pkg;

    // Register file.
    localparam int CFG_DATA_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RATE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SKIP_TICKS = 2'd1;
    localparam logic [CFG_DATA_WIDTH-1:0] RATE_LIMIT_RESET = 8'd220;
    localparam logic [CFG_DATA_WIDTH-1:0] SKIP_TICKS_RESET = 8'd10;

    // Result width.
    localparam int BPM_WIDTH = 8;

    // Dividend of the rate division: ticks per minute.
    localparam int NUM_WIDTH = 16;
    localparam logic [NUM_WIDTH-1:0] RATE_NUMERATOR = 16'd60000;
    localparam int STEP_CNT_W = $clog2(NUM_WIDTH);

    // Measurement phase.
    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_SKIP = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    // Top level sequencer.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_DONE   = 2'd2
    } t_seq_state;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hw/rtl/ppr_div.sv
// Restoring divider that computes RATE_NUMERATOR / divisor, one quotient bit per cycle.
// Depends on ppr_pkg.
module ppr_div #(
    parameter int DIVISOR_WIDTH = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIVISOR_WIDTH-1:0]      i_divisor,
    output ppr_pkg::t_div_stat            o_stat,
    output logic [ppr_pkg::NUM_WIDTH-1:0] o_quotient
);
    import ppr_pkg::*;

    logic                     r_busy;
    logic [STEP_CNT_W-1:0]    r_count;
    logic [DIVISOR_WIDTH-1:0] r_rem;
    logic [NUM_WIDTH-1:0]     r_quot;
    logic [DIVISOR_WIDTH-1:0] r_divisor;

    logic [DIVISOR_WIDTH:0]   trial;
    logic [DIVISOR_WIDTH:0]   diff;
    logic                     fits;

    // One trial subtraction per cycle; quotient bits shift in, dividend bits shift out.
    always_comb begin
        trial = {r_rem, r_quot[NUM_WIDTH-1]};
        diff  = trial - {1'b0, r_divisor};
        fits  = (trial >= {1'b0, r_divisor});
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= STEP_CNT_W'(NUM_WIDTH - 1);
        end else if (r_busy) begin
            if (r_count == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quot    <= RATE_NUMERATOR;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            r_quot <= {r_quot[NUM_WIDTH-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_count == '0);
    assign o_quotient  = r_quot;

endmodule

FILE: hw/rtl/pulse_period_to_rate.sv
// Top level of the pulse period to rate meter: tick phase tracking, sequencer, output register.
// Depends on ppr_pkg and ppr_div.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_pin_level
//  out     | output    | o_out_valid / i_out_ready | o_beats_per_minute, o_rate_valid
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_wdata
//
// A tick that produces no result leaves the sequencer in ST_IDLE. A tick that ends a low phase
// with the pin high starts the restoring divider; the sequencer waits in ST_DIVIDE until it is
// done, then in ST_DONE loads the result into the output register, and no new tick is accepted
// until it is back in ST_IDLE. The output register holds a finished result while new ticks are
// accepted; a finished quotient waits, with the input stalled, while that register is full.
// Reset is synchronous and active low; it restores the register defaults and the high phase.
module pulse_period_to_rate #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_pin_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ppr_pkg::BPM_WIDTH-1:0]       o_beats_per_minute,
    output logic                                o_rate_valid,
    input  logic                                i_cfg_we,
    input  logic [ppr_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [ppr_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata
);
    import ppr_pkg::*;

    localparam int DIVISOR_WIDTH = COUNT_WIDTH + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration registers.
    logic [CFG_DATA_WIDTH-1:0] r_rate_limit;
    logic [CFG_DATA_WIDTH-1:0] r_skip_ticks;

    // Measurement state.
    t_phase                    r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]    r_high_time, n_high_time;
    logic [COUNT_WIDTH-1:0]    r_low_time, n_low_time;
    logic [CFG_DATA_WIDTH-1:0] r_skip_left, n_skip_left;

    // Sequencer and result.
    t_seq_state                r_state, n_state;
    logic                      r_total_zero;
    logic                      r_out_valid;
    logic [BPM_WIDTH-1:0]      r_bpm;
    logic                      r_rate_ok;

    logic                      in_accept;
    logic                      div_start;
    logic                      out_load;
    logic [DIVISOR_WIDTH-1:0]  total;
    t_div_stat                 div_stat;
    logic [NUM_WIDTH-1:0]      quotient;
    logic                      result_ok;

    assign in_accept = i_in_valid && o_in_ready;
    assign total     = {1'b0, r_high_time} + {1'b0, r_low_time};

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_limit <= RATE_LIMIT_RESET;
            r_skip_ticks <= SKIP_TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_LIMIT: r_rate_limit <= i_cfg_wdata;
                CFG_SKIP_TICKS: r_skip_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Phase tracking for one accepted tick.
    always_comb begin
        n_phase     = r_phase;
        n_high_time = r_high_time;
        n_low_time  = r_low_time;
        n_skip_left = r_skip_left;
        unique case (r_phase)
            PH_SKIP: begin
                if (r_skip_left != '0) begin
                    n_skip_left = r_skip_left - 1'b1;
                end
                if (n_skip_left == '0) begin
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (!i_pin_level) begin
                    if (r_low_time != COUNT_MAX) begin
                        n_low_time = r_low_time + 1'b1;
                    end
                end else begin
                    // The rising edge counts as the first high tick of the next period.
                    n_phase     = PH_HIGH;
                    n_high_time = COUNT_WIDTH'(1);
                    n_low_time  = '0;
                    n_skip_left = '0;
                end
            end
            default: begin
                n_phase = PH_HIGH;
                if (i_pin_level) begin
                    if (r_high_time != COUNT_MAX) begin
                        n_high_time = r_high_time + 1'b1;
                    end
                end else begin
                    n_skip_left = r_skip_ticks;
                    n_phase     = (r_skip_ticks == '0) ? PH_LOW : PH_SKIP;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HIGH;
            r_high_time <= '0;
            r_low_time  <= '0;
            r_skip_left <= '0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_high_time <= n_high_time;
            r_low_time  <= n_low_time;
            r_skip_left <= n_skip_left;
        end
    end

    // Sequencer: accept ticks, run the divider, hand the result to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && (r_phase == PH_LOW) && i_pin_level) begin
                    div_start = 1'b1;
                    n_state   = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Zero total is flagged apart from the divider.
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_total_zero <= (total == '0);
        end
    end

    ppr_div #(
        .DIVISOR_WIDTH(DIVISOR_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (total),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // Result check against the rate limit.
    assign result_ok = !r_total_zero && (quotient < {{(NUM_WIDTH - CFG_DATA_WIDTH){1'b0}},
                                                     r_rate_limit});

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_bpm     <= result_ok ? quotient[BPM_WIDTH-1:0] : '0;
            r_rate_ok <= result_ok;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_beats_per_minute = r_bpm;
    assign o_rate_valid       = r_rate_ok;

    // The divider is never running while ticks are taken.
    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_stat.busy)
        else $error("tick accepted while the divider runs");

    // Divider completion is only seen while the sequencer waits for it.
    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    // A skip phase always has ticks left to ignore.
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip_left != '0))
        else $error("skip phase with no ticks left");

    // A failed result carries a zero rate.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rate_valid) |-> (o_beats_per_minute == '0))
        else $error("failed result with nonzero rate");

endmodule

FILE: dv/tb_pulse_period_to_rate.sv
// Self-checking testbench for the pulse period to rate meter.
// Drives millisecond ticks and register writes, predicts every rate result and checks it.
// Depends on ppr_pkg and pulse_period_to_rate.
module tb_pulse_period_to_rate;
    import ppr_pkg::*;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    // Drain time covers a divider run plus the output load, with margin.
    localparam int DRAIN_CYCLES = 24;
    localparam int DRAIN_LIMIT = 200000;
    localparam int HOLD_LEN = 400;
    localparam int RUN_LIMIT_CYCLES = 2500000;
    // Register indexes with no register behind them.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [BPM_WIDTH-1:0] bpm;
        logic                 valid;
    } t_rate;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_pin_level;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [BPM_WIDTH-1:0]       o_beats_per_minute;
    logic                       o_rate_valid;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_wdata;

    // Predicted meter state and registers.
    t_phase                     mtr_phase;
    logic [CNT_W-1:0]           mtr_high;
    logic [CNT_W-1:0]           mtr_low;
    logic [7:0]                 mtr_skip_left;
    logic [CFG_DATA_WIDTH-1:0]  mtr_rate_limit;
    logic [CFG_DATA_WIDTH-1:0]  mtr_skip_ticks;

    t_rate  pending_rates[$];
    int     live_ticks;
    int     rates_due;
    int     err_cnt;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_req_cnt;
    int     hold_ack_cnt = 0;
    int     hold_left = 0;

    pulse_period_to_rate #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_pin_level        (i_pin_level),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_beats_per_minute (o_beats_per_minute),
        .o_rate_valid       (o_rate_valid),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Only the first few mismatches are printed; the rest are counted.
    function automatic void log_mismatch(input string msg);
        if (err_cnt < 10) begin
            $display("mismatch: %s", msg);
        end
        err_cnt++;
    endfunction

    // Advance the predicted meter by one accepted tick and queue any rate it produces.
    task automatic advance_meter(input logic pin);
        logic [CNT_W:0] total;
        int unsigned    quot;
        t_rate          res;
        case (mtr_phase)
            PH_SKIP: begin
                if (mtr_skip_left != '0) mtr_skip_left--;
                if (mtr_skip_left == '0) mtr_phase = PH_LOW;
            end
            PH_LOW: begin
                live_ticks++;
                if (!pin) begin
                    if (mtr_low != CNT_MAX) mtr_low++;
                end else begin
                    total = {1'b0, mtr_high} + {1'b0, mtr_low};
                    res = '0;
                    // A zero total stays invalid with a zero rate.
                    if (total != '0) begin
                        quot = 32'(RATE_NUMERATOR) / 32'(total);
                        if (quot < 32'(mtr_rate_limit)) begin
                            res.valid = 1'b1;
                            res.bpm = BPM_WIDTH'(quot);
                        end
                    end
                    pending_rates.push_back(res);
                    rates_due++;
                    // The rising edge is already the first tick of the next high time.
                    mtr_phase = PH_HIGH;
                    mtr_high = CNT_W'(1);
                    mtr_low = '0;
                    mtr_skip_left = '0;
                end
            end
            default: begin
                live_ticks++;
                mtr_phase = PH_HIGH;
                if (pin) begin
                    if (mtr_high != CNT_MAX) mtr_high++;
                end else begin
                    mtr_skip_left = mtr_skip_ticks;
                    mtr_phase = (mtr_skip_ticks == '0) ? PH_LOW : PH_SKIP;
                end
            end
        endcase
    endtask

    // Offer one tick request, with an optional random idle gap ahead of it, and wait for acceptance.
    task automatic send_tick(input logic pin);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= pin;
        do @(posedge i_clk); while (!o_in_ready);
        advance_meter(pin);
    endtask

    // One pulse period: high ticks, the falling tick, the skipped ticks, low ticks, rising tick.
    task automatic send_period(input int high_extra, input int low_len);
        repeat (high_extra) send_tick(1'b1);
        send_tick(1'b0);
        repeat (mtr_skip_ticks) send_tick(1'($urandom_range(1)));
        repeat (low_len) send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Stop offering ticks and wait until every predicted rate has come out.
    task automatic settle_meter();
        int n;
        i_in_valid <= 1'b0;
        n = 0;
        while (pending_rates.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only issued while the meter is settled.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_RATE_LIMIT: mtr_rate_limit = val;
            CFG_SKIP_TICKS: mtr_skip_ticks = val;
            default: ;
        endcase
    endtask

    // Reset defaults: the first period after reset has nothing counted, so its total is zero.
    task automatic test_zero_total();
        send_tick(1'b0);
        repeat (mtr_skip_ticks) send_tick(1'($urandom_range(1)));
        send_tick(1'b1);
        send_period(3, 4);
        settle_meter();
    endtask

    // Rate limit edges: a rate just below the top limit, a rate equal to the limit,
    // a zero limit and a limit of one.
    task automatic test_rate_limit();
        write_reg(CFG_SKIP_TICKS, 8'd0);
        write_reg(CFG_RATE_LIMIT, 8'hFF);
        send_period(0, 235);
        settle_meter();
        write_reg(CFG_RATE_LIMIT, 8'hFE);
        send_period(0, 235);
        settle_meter();
        write_reg(CFG_RATE_LIMIT, 8'h00);
        send_period(2, 2);
        send_period(1, 0);
        settle_meter();
        write_reg(CFG_RATE_LIMIT, 8'd1);
        send_period(2, 2);
        settle_meter();
    endtask

    // Skip length just above zero.
    task automatic test_skip_ticks();
        write_reg(CFG_RATE_LIMIT, 8'd220);
        write_reg(CFG_SKIP_TICKS, 8'd1);
        send_period(0, 0);
        send_period(2, 5);
        settle_meter();
    endtask

    // Writes to indexes without a register must leave both registers alone.
    task automatic test_spare_index();
        write_reg(CFG_SKIP_TICKS, 8'd6);
        write_reg(CFG_SPARE_A, 8'd0);
        write_reg(CFG_SPARE_B, 8'hFF);
        send_period(2, 3);
        settle_meter();
    endtask

    // Receiver holds off for a long stretch while short periods keep the meter busy.
    task automatic test_backpressure();
        write_reg(CFG_RATE_LIMIT, 8'd220);
        write_reg(CFG_SKIP_TICKS, 8'd0);
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (10) begin
            send_tick(1'b0);
            send_tick(1'b1);
        end
        settle_meter();
    endtask

    // Short random periods mixed with noise runs that break the sequence.
    task automatic test_random(input int sidle, input int rstall,
                               input logic [CFG_DATA_WIDTH-1:0] lim,
                               input logic [CFG_DATA_WIDTH-1:0] skip);
        int sel;
        int tick_goal;
        int rate_goal;
        write_reg(CFG_RATE_LIMIT, lim);
        write_reg(CFG_SKIP_TICKS, skip);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        tick_goal = live_ticks + 16;
        rate_goal = rates_due + 2;
        while (live_ticks < tick_goal || rates_due < rate_goal) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)));
            end else begin
                send_period($urandom_range(4), $urandom_range(4));
            end
        end
        settle_meter();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver ready: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_LEN;
            i_out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted rate request with the oldest prediction.
    always @(posedge i_clk) begin
        t_rate got;
        t_rate want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.bpm = o_beats_per_minute;
            got.valid = o_rate_valid;
            if (pending_rates.size() == 0) begin
                log_mismatch($sformatf("unexpected rate bpm=%0d valid=%0b",
                                       got.bpm, got.valid));
            end else begin
                want = pending_rates.pop_front();
                if (got.bpm !== want.bpm || got.valid !== want.valid) begin
                    log_mismatch($sformatf("bpm exp=%0d act=%0d valid exp=%0b act=%0b",
                                           want.bpm, got.bpm, want.valid, got.valid));
                end
            end
        end
    end

    initial begin
        t_rate left;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_pin_level = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        hold_req_cnt = 0;
        live_ticks = 0;
        rates_due = 0;
        err_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mtr_phase = PH_HIGH;
        mtr_high = '0;
        mtr_low = '0;
        mtr_skip_left = '0;
        mtr_rate_limit = RATE_LIMIT_RESET;
        mtr_skip_ticks = SKIP_TICKS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_total();
        test_rate_limit();
        test_skip_ticks();
        test_spare_index();
        test_backpressure();
        test_random(0, 0, 8'd220, 8'd2);
        test_random(82, 0, 8'd128, 8'd0);
        test_random(0, 82, 8'd255, 8'd3);
        test_random(28, 28, 8'd60, 8'd1);

        settle_meter();
        while (pending_rates.size() != 0) begin
            left = pending_rates.pop_front();
            log_mismatch($sformatf("missing rate bpm=%0d valid=%0b", left.bpm, left.valid));
        end
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_div.sv
hw/rtl/pulse_period_to_rate.sv
dv/tb_pulse_period_to_rate.sv
